// File: rtl/core/ssms_pkg.sv
// ============================================================================
// ssms_pkg - shared types and constants for the stock span block
// Stack geometry, entry layout, RAM request bundle and ring address helper.
// ============================================================================
package ssms_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PRICE_W     = 32;
    localparam int DAY_W       = 32;

    localparam logic [DAY_W-1:0]  DAY_MAX   = {DAY_W{1'b1}};
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(STACK_DEPTH);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [DAY_W-1:0]   day;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_ram_req;

    // Fold base + offset (below twice the depth) back into the ring.
    function automatic t_addr f_wrap(input logic [ADDR_W:0] sum);
        logic [ADDR_W:0] folded;
        folded = (sum >= DEPTH_EXT) ? (sum - DEPTH_EXT) : sum;
        return folded[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/core/ssms_stack_ram.sv
// ============================================================================
// ssms_stack_ram - ring storage for the price/day stack
// One write port and one registered read port.
// ============================================================================
module ssms_stack_ram (
    input  logic              i_clk,
    input  ssms_pkg::t_ram_req i_req,
    output ssms_pkg::t_entry  o_rdata
);

    ssms_pkg::t_entry r_mem [ssms_pkg::STACK_DEPTH];
    ssms_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/stock_span_monotonic_stack.sv
// ============================================================================
// stock_span_monotonic_stack - online stock span over a monotonic stack
// Returns, per price, the run of consecutive prices at most the current one.
// ============================================================================
// Each request carries one 32-bit unsigned price and yields one result: the
// span (1 or more) and a sticky overflow flag. A request is accepted in
// IDLE, then takes one compare step per stack entry it pops plus the final
// compare, and one push step, which waits while the output register still
// holds an undelivered result. The single read port of the stack RAM yields
// one entry per cycle to the shared compare/subtract unit. Each entry is
// popped at most once. The input stall stays high while a request is at
// work; a finished result waits in the output register, and the next
// request can be taken meanwhile. The stack lives in a ring of STACK_DEPTH
// entries; when it is full, the oldest entry is dropped and overflow stays
// set from then on. The day counter saturates at its all-ones value. No
// clearing pass is needed after reset.
// ============================================================================
module stock_span_monotonic_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_price,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_span,
    output logic        o_overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                   r_state, n_state;
    ssms_pkg::t_cnt               r_cnt,   n_cnt;
    ssms_pkg::t_addr              r_base,  n_base;
    logic [ssms_pkg::DAY_W-1:0]   r_day,   n_day;
    logic                         r_ovf,   n_ovf;
    logic [ssms_pkg::PRICE_W-1:0] r_price, n_price;
    logic [31:0]                  r_span,  n_span;
    logic                         r_out_valid, n_out_valid;
    logic [31:0]                  r_out_span,  n_out_span;
    logic                         r_out_ovf,   n_out_ovf;

    ssms_pkg::t_ram_req           w_req;
    ssms_pkg::t_entry             w_top;
    logic [ssms_pkg::DAY_W-1:0]   w_diff;
    logic                         w_out_free;

    ssms_stack_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_top)
    );

    // Shared subtract for the non-empty span.
    assign w_diff     = r_day - w_top.day;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_day       = r_day;
        n_ovf       = r_ovf;
        n_price     = r_price;
        n_span      = r_span;
        n_out_valid = r_out_valid;
        n_out_span  = r_out_span;
        n_out_ovf   = r_out_ovf;
        w_req.we    = 1'b0;
        w_req.waddr = ssms_pkg::f_wrap({1'b0, r_base} + (ssms_pkg::ADDR_W + 1)'(r_cnt));
        w_req.wdata = '{price: r_price, day: r_day};

        // Drop the delivered result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_price = i_price;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                // The RAM output always holds the current top entry here.
                if (r_cnt == '0) begin
                    n_span  = (r_day == ssms_pkg::DAY_MAX) ? ssms_pkg::DAY_MAX
                                                          : r_day + 32'd1;
                    n_state = ST_PUSH;
                end else if (w_top.price <= r_price) begin
                    n_cnt = r_cnt - ssms_pkg::t_cnt'(1);
                end else begin
                    n_span  = (w_diff == '0) ? 32'd1 : w_diff;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // Hold until the output register is free, then push.
                if (w_out_free) begin
                    w_req.we = 1'b1;
                    if (r_cnt == ssms_pkg::DEPTH_CNT) begin
                        n_base = ssms_pkg::f_wrap({1'b0, r_base}
                                 + (ssms_pkg::ADDR_W + 1)'(1));
                        n_ovf  = 1'b1;
                    end else begin
                        n_cnt = r_cnt + ssms_pkg::t_cnt'(1);
                    end
                    if (r_day != ssms_pkg::DAY_MAX) begin
                        n_day = r_day + 32'd1;
                    end
                    n_out_valid = 1'b1;
                    n_out_span  = r_span;
                    n_out_ovf   = n_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Track the top of the next count so the compare sees it at once.
        w_req.raddr = ssms_pkg::f_wrap({1'b0, n_base}
                      + (ssms_pkg::ADDR_W + 1)'(n_cnt) - (ssms_pkg::ADDR_W + 1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_base      <= '0;
            r_day       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_base      <= n_base;
            r_day       <= n_day;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_price    <= n_price;
        r_span     <= n_span;
        r_out_span <= n_out_span;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_span      = r_out_span;
    assign o_overflow  = r_out_ovf;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ssms_pkg::DEPTH_CNT)
        else $error("stack count beyond depth");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span != 32'd0))
        else $error("zero span delivered");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    a_empty_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && r_cnt == '0) |=> (r_state == ST_PUSH))
        else $error("empty stack did not move to push");

endmodule

// File: tb/span_checker.sv
// ============================================================================
// span_checker - span predictor and result compare for the stock span block
// Mirrors the monotonic stack on every accepted request and checks each
// accepted result against the oldest predicted span and overflow flag.
// ============================================================================
`timescale 1ns / 1ps

module span_checker
    import ssms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [PRICE_W-1:0] i_price,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_span,
    input  logic               i_overflow,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [31:0] span;
        logic        overflow;
    } t_span_due;

    logic [PRICE_W-1:0] stk_price [STACK_DEPTH];
    logic [DAY_W-1:0]   stk_day   [STACK_DEPTH];
    int unsigned        depth_used;
    logic [DAY_W-1:0]   day_now;
    logic               ovf_sticky;
    t_span_due          span_due [$];

    initial begin
        o_errors   = 0;
        o_checked  = 0;
        depth_used = 0;
        day_now    = '0;
        ovf_sticky = 1'b0;
    end

    assign o_pending = span_due.size();

    // Pop lower or equal prices, work out the span, push today's pair.
    task automatic advance_span(input logic [PRICE_W-1:0] p, output t_span_due res);
        logic [DAY_W-1:0] d;
        logic [31:0]      span;
        d = day_now;
        while (depth_used > 0 && stk_price[depth_used-1] <= p)
            depth_used--;
        if (depth_used == 0) begin
            span = (d == DAY_MAX) ? DAY_MAX : d + 32'd1;
        end else begin
            span = d - stk_day[depth_used-1];
            if (span == 0)
                span = 1;
        end
        if (depth_used >= STACK_DEPTH) begin
            for (int k = 0; k < STACK_DEPTH - 1; k++) begin
                stk_price[k] = stk_price[k+1];
                stk_day[k]   = stk_day[k+1];
            end
            depth_used = STACK_DEPTH - 1;
            ovf_sticky = 1'b1;
        end
        stk_price[depth_used] = p;
        stk_day[depth_used]   = d;
        depth_used++;
        if (day_now != DAY_MAX)
            day_now++;
        res.span     = span;
        res.overflow = ovf_sticky;
    endtask

    always @(posedge i_clk) begin : watch
        t_span_due want;
        t_span_due got;
        if (!i_rst_n) begin
            depth_used = 0;
            day_now    = '0;
            ovf_sticky = 1'b0;
            span_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (span_due.size() == 0) begin
                    $error("unexpected result: span %0d overflow %0b", i_span, i_overflow);
                    o_errors++;
                end else begin
                    want = span_due.pop_front();
                    if (i_span !== want.span) begin
                        $error("span: expected %0d, actual %0d", want.span, i_span);
                        o_errors++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, i_overflow);
                        o_errors++;
                    end
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_span(i_price, got);
                span_due = {span_due, got};
            end
        end
    end

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench - stimulus and verdict for the stock span block
// Feeds directed, patterned random and deep falling price runs with random
// idling on both channels; a side checker predicts and compares the spans.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import ssms_pkg::*;

    // Upper bound on the whole run; the slowest correct run is far below it.
    localparam longint LIMIT_NS   = 64'd3_000_000;
    localparam int     HOLD_CYC   = 300;
    localparam int     DRAIN_CYC  = 40;
    localparam int     DESCENT_N  = 120;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [PRICE_W-1:0] price;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        span;
    logic               overflow;

    int                 err_count;
    int                 pending_count;
    int                 checked_count;

    // Shared knobs between the request driver and the result receiver.
    bit                 gaps_on;
    bit                 hold_req;
    int                 sent_count;
    logic [PRICE_W-1:0] last_price;

    stock_span_monotonic_stack uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_price     (price),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_span      (span),
        .o_overflow  (overflow)
    );

    span_checker u_span_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_price     (price),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_span      (span),
        .i_overflow  (overflow),
        .o_errors    (err_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request so
    // the block fills its output register and then stalls its input.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                out_stall = 1'b0;
                hold_req  = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    // Offer one price request; return at the falling edge after acceptance.
    // Valid stays high so a following request goes out back to back.
    task automatic send_price(input logic [PRICE_W-1:0] p);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        price    = p;
        do @(posedge i_clk); while (in_stall);
        sent_count++;
        last_price = p;
        @(negedge i_clk);
    endtask

    // Drive short runs of shaped prices: full random, walks near the last
    // price, rising and falling runs, flat runs and the range extremes.
    task automatic play_random_runs(input int n);
        int                 left;
        int                 run_len;
        int                 shape;
        logic [PRICE_W-1:0] p;
        logic [PRICE_W-1:0] step;
        left = n;
        while (left > 0) begin
            run_len = $urandom_range(1, 16);
            if (run_len > left)
                run_len = left;
            shape = $urandom_range(0, 5);
            p     = last_price;
            for (int k = 0; k < run_len; k++) begin
                step = $urandom_range(1, 1000);
                case (shape)
                    0: p = $urandom;
                    1: p = $urandom_range(0, 1) ? p + $urandom_range(0, 8)
                                               : p - $urandom_range(0, 8);
                    2: p = (p > DAY_MAX - step) ? '0 : p + step;
                    3: p = (p < step) ? DAY_MAX : p - step;
                    4: ;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: p = '0;
                            1: p = 32'd1;
                            2: p = DAY_MAX - 1;
                            default: p = DAY_MAX;
                        endcase
                    end
                endcase
                send_price(p);
            end
            left -= run_len;
        end
    endtask

    initial begin : stimulus
        logic [PRICE_W-1:0] directed [$];
        logic [PRICE_W-1:0] p;
        int                 waited;

        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        price      = '0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        sent_count = 0;
        last_price = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty stack, equal prices popping, the top price popping
        // everything, a falling run with a partial pop, and bit patterns.
        directed = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'd4,
                     32'd3, 32'd4, 32'd3, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF,
                     32'hFFFF_FFFE, 32'd0, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h5555_5555, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd0};
        foreach (directed[k])
            send_price(directed[k]);

        // Random shaped runs; midway, hold the result side off for a while
        // and keep offering requests against the backpressure.
        play_random_runs(140);
        hold_req = 1'b1;
        play_random_runs(190);

        // Deep stack: clear it with the top price, then fall strictly so
        // every request pushes without popping.
        send_price(DAY_MAX);
        p = DAY_MAX;
        for (int k = 0; k < DESCENT_N; k++) begin
            p = p - $urandom_range(1, 1000);
            send_price(p);
        end

        // Spans that reach part way back into the deep stack, then a top
        // price that empties it.
        send_price(p + 32'd50_000);
        send_price(p + 32'd100_000);
        send_price(DAY_MAX);
        send_price(32'd7);

        play_random_runs(50);

        // Last stretch with no idling on either side.
        gaps_on = 1'b0;
        play_random_runs(30);
        in_valid = 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("run covered %0d price requests and %0d checked spans", sent_count,
                 checked_count);
        $display("stack overflow flag at end of run: %0b, spans still owed: %0d",
                 overflow, pending_count);
        if (err_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
